[sv/pret_pkg.sv]
// Package: shared types and constants for the power residue edge test core
`timescale 1ns / 1ps
`default_nettype none
package pret_pkg;

	localparam int FIELD_BITS = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRAPH_KIND = 2'd2;

	localparam logic KIND_PALEY = 1'b0;
	localparam logic KIND_COMPL = 1'b1;

	typedef struct packed {
		logic [FIELD_BITS-1:0] vertex_a;
		logic [FIELD_BITS-1:0] vertex_b;
	} in_t;

	typedef struct packed {
		logic                  edge_res;
		logic [FIELD_BITS-1:0] least_non_power;
		logic                  no_non_power;
		logic                  bad_input;
	} out_t;

	typedef struct packed {
		logic start;
	} mm_req_t;

	typedef struct packed {
		logic done;
	} mm_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_EXP_INIT,
		ST_EXP_STEP,
		ST_MUL,
		ST_DIV,
		ST_WRITE,
		ST_SRCH_SET,
		ST_CHK_SET,
		ST_Q_A,
		ST_Q_B,
		ST_Q_C,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_ACC,
		OP_SQR
	} mm_op_t;

	typedef enum logic {
		PH_SRCH,
		PH_CHK
	} phase_t;

	localparam logic [2:0] CHK_LAST = 3'd4;

endpackage
`default_nettype wire

[sv/pret_mulmod.sv]
// Modular multiply unit: one multiply, then bit-serial remainder by the modulus
`timescale 1ns / 1ps
`default_nettype none
module pret_mulmod #(
	parameter int W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pret_pkg::mm_req_t req,
	input  wire logic [W-1:0]     x,
	input  wire logic [W-1:0]     y,
	input  wire logic [W-1:0]     m,
	output pret_pkg::mm_rsp_t     rsp,
	output logic [W-1:0]          rem
);
	import pret_pkg::*;

	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW);
	localparam logic [CW-1:0] LAST = CW'(PW - 1);

	logic [PW-1:0] prod_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_nx;

	always_comb begin
		rem_sh = {rem_q[W-1:0], prod_q[PW-1]};
		rem_nx = (rem_sh >= {1'b0, m}) ? rem_sh - {1'b0, m} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= {{W{1'b0}}, x} * {{W{1'b0}}, y};
			rem_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			rem_q  <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rem      = rem_q[W-1:0];

endmodule
`default_nettype wire

[sv/power_residue_edge_test_core.sv]
// Top level: generalized power residue graph edge test with residue table
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data (vertex_a, vertex_b)
// out     | output    | out_valid / out_ready | out_data (edge, least, none, bad)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Per request: a clear pass over residue table entries 0 to m, then for each
// base below m a square-and-multiply, each modular product computed in the
// shared multiply/remainder unit; then each table lookup runs through a set
// state and Q_A, Q_B, Q_C. Reset restores idle control and default
// configuration; the table is rewritten by every request that passes the
// input checks. A finished result sits in the output register, so a new
// request may start while it waits.
`timescale 1ns / 1ps
`default_nettype none
module power_residue_edge_test_core #(
	parameter int VALUE_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire pret_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output pret_pkg::out_t                       out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pret_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [pret_pkg::FIELD_BITS-1:0]   cfg_data
);
	import pret_pkg::*;

	localparam int W = VALUE_BITS;
	localparam int DEPTH = 2 ** W;

	logic [W-1:0]          mod_q;
	logic [FIELD_BITS-1:0] exp_q;
	logic                  kind_q;

	state_t state_q, state_d;

	logic [W-1:0]          a_q, b_q, i_q, j_q, clr_q, n_q, acc_q, base_q, least_q;
	logic [FIELD_BITS-1:0] e_q;
	logic                  accd_q, mode_q, bad_q, none_q, edge_q, h1_q;
	logic [2:0]            k_q;
	mm_op_t                op_q;
	phase_t                ph_q;

	logic                  mem [DEPTH];
	logic                  rd_q;
	logic                  we;
	logic [W-1:0]          wa, ra;
	logic                  wd;

	mm_req_t               mm_req;
	mm_rsp_t               mm_rsp;
	logic [W-1:0]          mm_x, mm_y, mm_rem;

	logic                  out_valid_q;
	out_t                  out_q;

	logic                  in_acc, cnt, want, bad_in;
	logic [W-1:0]          a_in, b_in, cval, qx, qy, diff;
	logic [FIELD_BITS-1:0] e_sh;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign a_in   = in_data.vertex_a[W-1:0];
	assign b_in   = in_data.vertex_b[W-1:0];
	assign bad_in = (a_in >= mod_q) || (b_in >= mod_q);
	assign cnt    = h1_q | rd_q;
	assign want   = (mode_q == KIND_PALEY);
	assign e_sh   = e_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(13);
			exp_q  <= FIELD_BITS'(2);
			kind_q <= KIND_PALEY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODULUS:    mod_q  <= cfg_data[W-1:0];
				CFG_EXPONENT:   exp_q  <= cfg_data;
				CFG_GRAPH_KIND: kind_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (mode_q == KIND_PALEY) cval = (mod_q == W'(1)) ? '0 : W'(1);
		else                      cval = (least_q == mod_q) ? '0 : least_q;
		case (k_q)
			3'd0: begin qx = a_q; qy = b_q; end
			3'd1: begin qx = a_q; qy = '0; end
			3'd2: begin qx = a_q; qy = cval; end
			3'd3: begin qx = b_q; qy = '0; end
			default: begin qx = b_q; qy = cval; end
		endcase
		diff = (qx >= qy) ? qx - qy : qx + (mod_q - qy);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (mod_q == '0 || (kind_q == KIND_PALEY && bad_in)) state_d = ST_DONE;
					else state_d = ST_CLR;
				end
			end
			ST_CLR:      if (clr_q == mod_q) state_d = ST_EXP_INIT;
			ST_EXP_INIT: state_d = ST_EXP_STEP;
			ST_EXP_STEP: begin
				if (e_q == '0) state_d = ST_WRITE;
				else if (e_q[0] && !accd_q) state_d = ST_MUL;
				else if (e_sh != '0) state_d = ST_MUL;
			end
			ST_MUL:      state_d = ST_DIV;
			ST_DIV:      if (mm_rsp.done) state_d = ST_EXP_STEP;
			ST_WRITE: begin
				if (i_q != mod_q - W'(1)) state_d = ST_EXP_INIT;
				else if (mode_q == KIND_COMPL) state_d = ST_SRCH_SET;
				else state_d = ST_CHK_SET;
			end
			ST_SRCH_SET: state_d = ST_Q_A;
			ST_CHK_SET:  state_d = ST_Q_A;
			ST_Q_A:      state_d = ST_Q_B;
			ST_Q_B:      state_d = ST_Q_C;
			ST_Q_C: begin
				if (ph_q == PH_SRCH) begin
					if (!cnt) state_d = bad_q ? ST_DONE : ST_CHK_SET;
					else if (j_q == mod_q) state_d = ST_DONE;
					else state_d = ST_SRCH_SET;
				end else begin
					if (cnt != want || k_q == CHK_LAST) state_d = ST_DONE;
					else state_d = ST_CHK_SET;
				end
			end
			ST_DONE:     if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we         = 1'b0;
		wa         = clr_q;
		wd         = 1'b0;
		ra         = (state_q == ST_Q_B) ? mod_q - n_q : n_q;
		mm_req.start = (state_q == ST_MUL);
		mm_x       = (op_q == OP_ACC) ? acc_q : base_q;
		mm_y       = base_q;
		case (state_q)
			ST_CLR:   begin we = 1'b1; wa = clr_q; wd = 1'b0; end
			ST_WRITE: begin we = 1'b1; wa = acc_q; wd = 1'b1; end
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q     <= a_in;
				b_q     <= b_in;
				mode_q  <= kind_q;
				bad_q   <= bad_in;
				none_q  <= (mod_q == '0) && (kind_q == KIND_COMPL);
				least_q <= '0;
				edge_q  <= 1'b0;
				clr_q   <= '0;
				i_q     <= '0;
				j_q     <= W'(1);
				k_q     <= '0;
			end
			ST_CLR: clr_q <= clr_q + W'(1);
			ST_EXP_INIT: begin
				acc_q  <= W'(1);
				base_q <= i_q;
				e_q    <= exp_q;
				accd_q <= 1'b0;
			end
			ST_EXP_STEP: begin
				if (e_q != '0) begin
					if (e_q[0] && !accd_q) begin
						op_q <= OP_ACC;
					end else if (e_sh != '0) begin
						op_q <= OP_SQR;
					end else begin
						e_q    <= '0;
						accd_q <= 1'b0;
					end
				end
			end
			ST_DIV: begin
				if (mm_rsp.done) begin
					if (op_q == OP_ACC) begin
						acc_q  <= mm_rem;
						accd_q <= 1'b1;
					end else begin
						base_q <= mm_rem;
						e_q    <= e_sh;
						accd_q <= 1'b0;
					end
				end
			end
			ST_WRITE: i_q <= i_q + W'(1);
			ST_SRCH_SET: begin
				n_q  <= (j_q == mod_q) ? '0 : j_q;
				ph_q <= PH_SRCH;
			end
			ST_CHK_SET: begin
				n_q  <= diff;
				ph_q <= PH_CHK;
			end
			ST_Q_B: h1_q <= rd_q;
			ST_Q_C: begin
				if (ph_q == PH_SRCH) begin
					if (!cnt) least_q <= j_q;
					else if (j_q == mod_q) none_q <= 1'b1;
					else j_q <= j_q + W'(1);
				end else begin
					if (cnt == want && k_q == CHK_LAST) edge_q <= 1'b1;
					k_q <= k_q + 3'd1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.edge_res        <= edge_q;
					out_q.least_non_power <= FIELD_BITS'(least_q);
					out_q.no_non_power    <= none_q;
					out_q.bad_input       <= bad_q;
				end
			end
			default: ;
		endcase
	end

	pret_mulmod #(.W(W)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.x      (mm_x),
		.y      (mm_y),
		.m      (mod_q),
		.rsp    (mm_rsp),
		.rem    (mm_rem)
	);

endmodule
`default_nettype wire
